// File: hw/rtl/nmea_sentence_field_parser_unit_macros.svh
// ============================================================================
// NMEA sentence field parser assertion macros
// Clocked assertion shorthands used by the parser RTL; define ASSERT_OFF to
// compile them out.
// ============================================================================
`ifndef NMEA_SENTENCE_FIELD_PARSER_UNIT_MACROS_SVH
`define NMEA_SENTENCE_FIELD_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// condition must hold at every clock edge out of reset
`define NSFP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define NSFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSFP_ASSERT(label, cond, msg)
`define NSFP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/nsfp_pkg.sv
// ============================================================================
// NMEA sentence field parser package
// Character codes, header names, field positions, limits and helper
// functions shared by the parser RTL.
// ============================================================================
package nsfp_pkg;

    localparam logic [7:0]  SENTENCE_MAX = 8'd128;
    localparam logic [7:0]  HDR_LEN      = 8'd6;
    localparam logic [4:0]  COMMA_SAT    = 5'd31;
    localparam logic [2:0]  FRAC_STOP    = 3'd7;
    localparam logic [31:0] ACC_MAX      = 32'hFFFF_FFFF;
    localparam logic [31:0] LETTER_MORE  = 32'h0000_0200;

    localparam logic [47:0] HDR_RMC = 48'h2447_5052_4D43;
    localparam logic [47:0] HDR_GGA = 48'h2447_5047_4741;
    localparam logic [47:0] HDR_GSV = 48'h2447_5047_5356;
    localparam logic [47:0] HDR_GSA = 48'h2447_5047_5341;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;

    // field positions (comma index) inside a sentence
    localparam logic [4:0] IDX_TIME = 5'd1;
    localparam logic [4:0] IDX_LAT  = 5'd3;
    localparam logic [4:0] IDX_LATH = 5'd4;
    localparam logic [4:0] IDX_LON  = 5'd5;
    localparam logic [4:0] IDX_LONH = 5'd6;
    localparam logic [4:0] IDX_FIX  = 5'd6;
    localparam logic [4:0] IDX_SATS = 5'd7;
    localparam logic [4:0] IDX_ALT  = 5'd9;

    localparam logic [31:0] TIME_MAX   = 32'd23595999;
    localparam logic [31:0] LAT_MAX    = 32'd90000000;
    localparam logic [31:0] LON_MAX    = 32'd180000000;
    localparam logic [31:0] SATS_MAX   = 32'd99;
    localparam logic [31:0] ALT_HI_MAG = 32'd1000000;
    localparam logic [31:0] ALT_LO_MAG = 32'd100000;
    localparam logic signed [20:0] ALT_HI = 21'sd1000000;
    localparam logic signed [20:0] ALT_LO = -21'sd100000;

    localparam logic [1:0] HEMI_NONE = 2'd0;
    localparam logic [1:0] HEMI_POS  = 2'd1;
    localparam logic [1:0] HEMI_NEG  = 2'd2;

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_RMC,
        KIND_GGA,
        KIND_GSX
    } kind_t;

    typedef enum logic [3:0] {
        ROLE_NONE,
        ROLE_TIME,
        ROLE_LAT,
        ROLE_LATH,
        ROLE_LON,
        ROLE_LONH,
        ROLE_FIX,
        ROLE_SATS,
        ROLE_ALT
    } role_t;

    function automatic kind_t kind_of(input logic [47:0] hdr);
        kind_t k;
        if (hdr == HDR_RMC) k = KIND_RMC;
        else if (hdr == HDR_GGA) k = KIND_GGA;
        else if (hdr == HDR_GSV || hdr == HDR_GSA) k = KIND_GSX;
        else k = KIND_OTHER;
        return k;
    endfunction

    function automatic role_t role_of(input kind_t kind, input logic [4:0] idx);
        role_t r;
        r = ROLE_NONE;
        if (kind == KIND_RMC) begin
            if (idx == IDX_TIME) r = ROLE_TIME;
            else if (idx == IDX_LAT) r = ROLE_LAT;
            else if (idx == IDX_LATH) r = ROLE_LATH;
            else if (idx == IDX_LON) r = ROLE_LON;
            else if (idx == IDX_LONH) r = ROLE_LONH;
        end
        else if (kind == KIND_GGA) begin
            if (idx == IDX_FIX) r = ROLE_FIX;
            else if (idx == IDX_SATS) r = ROLE_SATS;
            else if (idx == IDX_ALT) r = ROLE_ALT;
        end
        return r;
    endfunction

    // fraction digits kept for a numeric field
    function automatic logic [2:0] scale_of(input role_t role);
        logic [2:0] s;
        unique case (role)
            ROLE_TIME:          s = 3'd2;
            ROLE_LAT, ROLE_LON: s = 3'd4;
            ROLE_ALT:           s = 3'd1;
            default:            s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [13:0] pow10(input logic [2:0] k);
        logic [13:0] p;
        unique case (k)
            3'd0:    p = 14'd1;
            3'd1:    p = 14'd10;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd1000;
            default: p = 14'd10000;
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/nmea_sentence_field_parser_unit.sv
// ============================================================================
// NMEA sentence field parser
// Frames received characters into NMEA lines, decodes RMC and GGA fields to
// fixed point and emits one status item per line.
// ============================================================================
// Input channel: in_valid/in_ready carry one received character (rx_byte).
// A line ends at a newline, or at the first character that arrives after
// SENTENCE_MAX characters were taken; that character is dropped.
// Output channel: out_valid/out_ready carry one status item per line with
// the sentence kind and the latest time, position, fix, satellite and
// altitude values, plus pair_complete (RMC and GGA-class both seen since the
// last pair, after which both marks clear).
// Throughput: one character per cycle while no line end is held. Each
// character sits in an input register, then a single pass of field logic
// (one 32x14 multiply for decimal scaling) updates the stores and the output
// register; a line end leaving the input register loads the status item.
// Stall: while a status item waits, plain characters keep flowing; a line
// end is held in the input register until the output register frees up.
// Reset: all stores, counters and marks clear; both channels go idle.
// ============================================================================
`include "nmea_sentence_field_parser_unit_macros.svh"

module nmea_sentence_field_parser_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         sentence_kind,
    output logic [26:0]        latitude,
    output logic [1:0]         lat_hemisphere,
    output logic [27:0]        longitude,
    output logic [1:0]         lon_hemisphere,
    output logic [24:0]        utc_time,
    output logic               fix_seen,
    output logic [6:0]         sats_tracked,
    output logic signed [20:0] altitude_tenths,
    output logic               pair_complete
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  byte_reg;

    // line and field state
    logic [47:0] header_reg, header_next;
    logic [7:0]  char_count_reg, char_count_next;
    logic [4:0]  comma_count_reg, comma_count_next;
    logic [2:0]  frac_reg, frac_next;
    logic        point_reg, point_next;
    logic        minus_reg, minus_next;
    logic [31:0] accum_reg, accum_next;

    // stores
    logic [26:0]        lat_reg, lat_next;
    logic [27:0]        lon_reg, lon_next;
    logic [1:0]         lat_hemi_reg, lat_hemi_next;
    logic [1:0]         lon_hemi_reg, lon_hemi_next;
    logic [24:0]        time_reg, time_next;
    logic signed [20:0] alt_reg, alt_next;
    logic [6:0]         sats_reg, sats_next;
    logic               fix_reg, fix_next;
    logic               rmc_seen_reg, rmc_seen_next;
    logic               gga_seen_reg, gga_seen_next;

    // output register
    logic               out_valid_reg;
    logic [1:0]         out_kind_reg;
    logic [26:0]        out_lat_reg;
    logic [1:0]         out_lat_hemi_reg;
    logic [27:0]        out_lon_reg;
    logic [1:0]         out_lon_hemi_reg;
    logic [24:0]        out_time_reg;
    logic               out_fix_reg;
    logic [6:0]         out_sats_reg;
    logic signed [20:0] out_alt_reg;
    logic               out_pair_reg;

    // control
    logic               is_eol, is_comma, is_digit;
    logic               proc_go;
    logic               do_line, do_comma, do_hdr, do_feed, do_end, do_commit;
    logic               hdr_bad;
    nsfp_pkg::kind_t    kind;
    nsfp_pkg::role_t    role;
    logic [2:0]         scale, frac_eff, shift_k;
    logic               letter_role;

    // datapath
    logic [45:0]        prod;
    logic [31:0]        norm_val;
    logic [35:0]        mac_sum;
    logic [31:0]        mac_val;
    logic [3:0]         digit;
    logic               neg;
    logic [24:0]        time_val;
    logic [26:0]        lat_val;
    logic [27:0]        lon_val;
    logic [6:0]         sats_val;
    logic signed [20:0] alt_val;
    logic [1:0]         lat_code, lon_code;
    logic               fix_hit;
    logic               rmc_now, gga_now, pair;

    assign is_eol   = (byte_reg == nsfp_pkg::CH_NL) || (char_count_reg >= nsfp_pkg::SENTENCE_MAX);
    assign is_comma = (byte_reg == nsfp_pkg::CH_COMMA);
    assign is_digit = (byte_reg >= nsfp_pkg::CH_ZERO) && (byte_reg <= nsfp_pkg::CH_NINE);

    // a line end needs the output register, other characters never wait
    assign proc_go  = in_valid_reg && (!is_eol || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || proc_go;

    assign do_line   = proc_go && !is_eol;
    assign do_comma  = do_line && is_comma;
    assign do_hdr    = do_line && !is_comma && (comma_count_reg == 5'd0);
    assign do_feed   = do_line && !is_comma && (comma_count_reg != 5'd0);
    assign do_end    = proc_go && is_eol;
    assign do_commit = do_comma || do_end;

    // header counts only if exactly six characters came before the first comma
    assign hdr_bad     = (comma_count_reg == 5'd0) && (char_count_reg != nsfp_pkg::HDR_LEN);
    assign kind        = nsfp_pkg::kind_of(hdr_bad ? 48'd0 : header_reg);
    assign role        = nsfp_pkg::role_of(kind, comma_count_reg);
    assign scale       = nsfp_pkg::scale_of(role);
    assign letter_role = (role == nsfp_pkg::ROLE_LATH) || (role == nsfp_pkg::ROLE_LONH)
                         || (role == nsfp_pkg::ROLE_FIX);

    // scale the mantissa up to the field's fraction digits, saturating
    assign frac_eff = point_reg ? frac_reg : 3'd0;
    assign shift_k  = (frac_eff >= scale) ? 3'd0 : 3'(scale - frac_eff);
    assign prod     = accum_reg * nsfp_pkg::pow10(shift_k);
    assign norm_val = (frac_reg == nsfp_pkg::FRAC_STOP) ? accum_reg
                    : ((|prod[45:32]) ? nsfp_pkg::ACC_MAX : prod[31:0]);

    // one decimal digit into the accumulator, saturating
    assign digit   = 4'(byte_reg - nsfp_pkg::CH_ZERO);
    assign mac_sum = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0} + {32'd0, digit};
    assign mac_val = (|mac_sum[35:32]) ? nsfp_pkg::ACC_MAX : mac_sum[31:0];

    // clamp committed numbers to their field ranges
    assign neg      = minus_reg && (norm_val != 32'd0);
    assign time_val = neg ? 25'd0
                    : ((norm_val > nsfp_pkg::TIME_MAX) ? nsfp_pkg::TIME_MAX[24:0] : norm_val[24:0]);
    assign lat_val  = neg ? 27'd0
                    : ((norm_val > nsfp_pkg::LAT_MAX) ? nsfp_pkg::LAT_MAX[26:0] : norm_val[26:0]);
    assign lon_val  = neg ? 28'd0
                    : ((norm_val > nsfp_pkg::LON_MAX) ? nsfp_pkg::LON_MAX[27:0] : norm_val[27:0]);
    assign sats_val = neg ? 7'd0
                    : ((norm_val > nsfp_pkg::SATS_MAX) ? nsfp_pkg::SATS_MAX[6:0] : norm_val[6:0]);

    always_comb
    begin
        if (minus_reg) begin
            if (norm_val > nsfp_pkg::ALT_LO_MAG)
                alt_val = nsfp_pkg::ALT_LO;
            else
                alt_val = -$signed({1'b0, norm_val[19:0]});
        end
        else begin
            if (norm_val > nsfp_pkg::ALT_HI_MAG)
                alt_val = nsfp_pkg::ALT_HI;
            else
                alt_val = $signed({1'b0, norm_val[19:0]});
        end
    end

    always_comb
    begin
        if (accum_reg == {23'd0, 1'b1, nsfp_pkg::CH_N})
            lat_code = nsfp_pkg::HEMI_POS;
        else if (accum_reg == {23'd0, 1'b1, nsfp_pkg::CH_S})
            lat_code = nsfp_pkg::HEMI_NEG;
        else
            lat_code = nsfp_pkg::HEMI_NONE;

        if (accum_reg == {23'd0, 1'b1, nsfp_pkg::CH_E})
            lon_code = nsfp_pkg::HEMI_POS;
        else if (accum_reg == {23'd0, 1'b1, nsfp_pkg::CH_W})
            lon_code = nsfp_pkg::HEMI_NEG;
        else
            lon_code = nsfp_pkg::HEMI_NONE;
    end

    assign fix_hit = (accum_reg == {23'd0, 1'b1, nsfp_pkg::CH_ONE});

    // field accumulator
    always_comb
    begin
        accum_next = accum_reg;
        frac_next  = frac_reg;
        point_next = point_reg;
        minus_next = minus_reg;
        if (do_commit) begin
            accum_next = 32'd0;
            frac_next  = 3'd0;
            point_next = 1'b0;
            minus_next = 1'b0;
        end
        else if (do_feed && letter_role) begin
            // remember a lone first character, mark anything longer
            accum_next = (accum_reg == 32'd0) ? {23'd0, 1'b1, byte_reg} : nsfp_pkg::LETTER_MORE;
        end
        else if (do_feed && (role != nsfp_pkg::ROLE_NONE)
                 && (frac_reg != nsfp_pkg::FRAC_STOP)) begin
            priority if (is_digit) begin
                if (!point_reg) begin
                    accum_next = mac_val;
                    frac_next  = 3'd1;
                end
                else if (frac_reg < scale) begin
                    accum_next = mac_val;
                    frac_next  = frac_reg + 3'd1;
                end
            end
            else if (byte_reg == nsfp_pkg::CH_DOT && !point_reg) begin
                point_next = 1'b1;
                frac_next  = 3'd0;
            end
            else if ((byte_reg == nsfp_pkg::CH_MINUS || byte_reg == nsfp_pkg::CH_PLUS)
                     && !point_reg && frac_reg == 3'd0 && !minus_reg) begin
                if (byte_reg == nsfp_pkg::CH_MINUS)
                    minus_next = 1'b1;
                else
                    frac_next = 3'd1;
            end
            else begin
                // any other character finishes the number
                accum_next = norm_val;
                frac_next  = nsfp_pkg::FRAC_STOP;
            end
        end
    end

    // stores: commit the current field; at the end of an RMC or GGA line also zero its missing fields, fix apart
    always_comb
    begin
        time_next     = time_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        lat_hemi_next = lat_hemi_reg;
        lon_hemi_next = lon_hemi_reg;
        sats_next     = sats_reg;
        alt_next      = alt_reg;
        fix_next      = fix_reg;
        if (do_commit) begin
            unique case (role)
                nsfp_pkg::ROLE_TIME: time_next = time_val;
                nsfp_pkg::ROLE_LAT:  lat_next = lat_val;
                nsfp_pkg::ROLE_LON:  lon_next = lon_val;
                nsfp_pkg::ROLE_LATH: lat_hemi_next = lat_code;
                nsfp_pkg::ROLE_LONH: lon_hemi_next = lon_code;
                nsfp_pkg::ROLE_SATS: sats_next = sats_val;
                nsfp_pkg::ROLE_ALT:  alt_next = alt_val;
                nsfp_pkg::ROLE_FIX:  fix_next = fix_reg | fix_hit;
                default:             ;
            endcase
        end
        if (do_end && kind == nsfp_pkg::KIND_RMC) begin
            if (comma_count_reg < nsfp_pkg::IDX_TIME) time_next = 25'd0;
            if (comma_count_reg < nsfp_pkg::IDX_LAT)  lat_next = 27'd0;
            if (comma_count_reg < nsfp_pkg::IDX_LATH) lat_hemi_next = nsfp_pkg::HEMI_NONE;
            if (comma_count_reg < nsfp_pkg::IDX_LON)  lon_next = 28'd0;
            if (comma_count_reg < nsfp_pkg::IDX_LONH) lon_hemi_next = nsfp_pkg::HEMI_NONE;
        end
        if (do_end && kind == nsfp_pkg::KIND_GGA) begin
            if (comma_count_reg < nsfp_pkg::IDX_SATS) sats_next = 7'd0;
            if (comma_count_reg < nsfp_pkg::IDX_ALT)  alt_next = 21'sd0;
        end
    end

    // line framing and received marks
    always_comb
    begin
        header_next      = header_reg;
        char_count_next  = char_count_reg;
        comma_count_next = comma_count_reg;
        if (do_line)
            char_count_next = char_count_reg + 8'd1;
        if (do_hdr)
            header_next = {header_reg[39:0], byte_reg};
        if (do_comma && hdr_bad)
            header_next = 48'd0;
        if (do_comma && comma_count_reg != nsfp_pkg::COMMA_SAT)
            comma_count_next = comma_count_reg + 5'd1;
        if (do_end) begin
            header_next      = 48'd0;
            char_count_next  = 8'd0;
            comma_count_next = 5'd0;
        end
    end

    assign rmc_now = rmc_seen_reg || (kind == nsfp_pkg::KIND_RMC);
    assign gga_now = gga_seen_reg || (kind == nsfp_pkg::KIND_GGA) || (kind == nsfp_pkg::KIND_GSX);
    assign pair    = rmc_now && gga_now;

    always_comb
    begin
        rmc_seen_next = rmc_seen_reg;
        gga_seen_next = gga_seen_reg;
        if (do_end) begin
            rmc_seen_next = rmc_now && !pair;
            gga_seen_next = gga_now && !pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            header_reg      <= 48'd0;
            char_count_reg  <= 8'd0;
            comma_count_reg <= 5'd0;
            frac_reg        <= 3'd0;
            point_reg       <= 1'b0;
            minus_reg       <= 1'b0;
            accum_reg       <= 32'd0;
            lat_reg         <= 27'd0;
            lon_reg         <= 28'd0;
            lat_hemi_reg    <= nsfp_pkg::HEMI_NONE;
            lon_hemi_reg    <= nsfp_pkg::HEMI_NONE;
            time_reg        <= 25'd0;
            alt_reg         <= 21'sd0;
            sats_reg        <= 7'd0;
            fix_reg         <= 1'b0;
            rmc_seen_reg    <= 1'b0;
            gga_seen_reg    <= 1'b0;
        end
        else begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (do_end)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            header_reg      <= header_next;
            char_count_reg  <= char_count_next;
            comma_count_reg <= comma_count_next;
            frac_reg        <= frac_next;
            point_reg       <= point_next;
            minus_reg       <= minus_next;
            accum_reg       <= accum_next;
            lat_reg         <= lat_next;
            lon_reg         <= lon_next;
            lat_hemi_reg    <= lat_hemi_next;
            lon_hemi_reg    <= lon_hemi_next;
            time_reg        <= time_next;
            alt_reg         <= alt_next;
            sats_reg        <= sats_next;
            fix_reg         <= fix_next;
            rmc_seen_reg    <= rmc_seen_next;
            gga_seen_reg    <= gga_seen_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= rx_byte;
        if (do_end) begin
            out_kind_reg     <= 2'(kind);
            out_lat_reg      <= lat_next;
            out_lat_hemi_reg <= lat_hemi_next;
            out_lon_reg      <= lon_next;
            out_lon_hemi_reg <= lon_hemi_next;
            out_time_reg     <= time_next;
            out_fix_reg      <= fix_next;
            out_sats_reg     <= sats_next;
            out_alt_reg      <= alt_next;
            out_pair_reg     <= pair;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sentence_kind   = out_kind_reg;
    assign latitude        = out_lat_reg;
    assign lat_hemisphere  = out_lat_hemi_reg;
    assign longitude       = out_lon_reg;
    assign lon_hemisphere  = out_lon_hemi_reg;
    assign utc_time        = out_time_reg;
    assign fix_seen        = out_fix_reg;
    assign sats_tracked    = out_sats_reg;
    assign altitude_tenths = out_alt_reg;
    assign pair_complete   = out_pair_reg;

    `NSFP_ASSERT(a_count_bound, char_count_reg <= nsfp_pkg::SENTENCE_MAX, "line count past limit")
    `NSFP_ASSERT(a_commas_in_line, comma_count_reg <= char_count_reg, "more commas than characters")
    `NSFP_ASSERT(a_frac_range, frac_reg != 3'd5 && frac_reg != 3'd6, "fraction count out of range")
    `NSFP_ASSERT_NEXT(a_line_restart, do_end, char_count_reg == 8'd0 && comma_count_reg == 5'd0, "line state not cleared after line end")
    `NSFP_ASSERT(a_pair_clears, !(out_valid_reg && out_pair_reg) || (!rmc_seen_reg && !gga_seen_reg), "received marks left set after pair")

endmodule
